// ===== src/stt_pkg.sv =====
// Shared types and constants of the search transposition table.
package stt_pkg;

	localparam int SCORE_W    = 31;
	localparam int MOVE_W     = 32;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 30;
	localparam int ADJ_W      = 33;

	localparam logic OP_STORE = 1'b1;

	localparam logic [1:0] BOUND_EXACT = 2'd0;
	localparam logic [1:0] BOUND_LOWER = 2'd1;
	localparam logic [1:0] BOUND_UPPER = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_AGE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MATE = 1'b1;

	localparam logic signed [31:0] MATE_WINDOW  = 32'sd1000;
	localparam logic signed [31:0] PLY_EXTRA    = 32'sd1;
	localparam logic signed [31:0] MATE_RESET   = 32'sd32000;
	localparam logic signed [31:0] THR_HI_RESET = MATE_RESET - MATE_WINDOW;
	localparam logic signed [31:0] THR_LO_RESET = MATE_WINDOW - MATE_RESET;

	localparam logic signed [ADJ_W-1:0] SCORE_MAX = 33'sd1073741823;
	localparam logic signed [ADJ_W-1:0] SCORE_MIN = -33'sd1073741824;

	// Probe or store outcome handed from the read-modify-write stage to scoring
	typedef struct packed {
		logic                      replaced;
		logic                      key_hit;
		logic                      depth_hit;
		logic [1:0]                bound;
		logic signed [ADJ_W-1:0]   adj;
		logic signed [SCORE_W-1:0] alpha;
		logic signed [SCORE_W-1:0] beta;
		logic [MOVE_W-1:0]         found_move;
	} stt_s2_t;

endpackage

// ===== src/stt_ram.sv =====
// Generic single-port-write, registered-read RAM.
module stt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [$clog2(DEPTH)-1:0]       waddr,
	input  logic [WIDTH-1:0]               wdata,
	input  logic                           re,
	input  logic [$clog2(DEPTH)-1:0]       raddr,
	output logic [WIDTH-1:0]               rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/stt_score_out.sv =====
// Cutoff test, score saturation and output register of probe and store results.
module stt_score_out
	import stt_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s1_valid,
	output logic                      s1_ready,
	input  stt_s2_t                   s1_data,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      replaced,
	output logic                      key_hit,
	output logic                      depth_hit,
	output logic                      cutoff,
	output logic signed [SCORE_W-1:0] found_score,
	output logic [MOVE_W-1:0]         found_move
);

	logic    valid_s2;
	stt_s2_t data_s2;
	logic    out_valid_q;
	logic    load_out;
	logic    cut;
	logic signed [ADJ_W-1:0]   alpha_x;
	logic signed [ADJ_W-1:0]   beta_x;
	logic signed [SCORE_W-1:0] sat;

	assign load_out = valid_s2 && (!out_valid_q || !out_stall);
	assign s1_ready = !valid_s2 || load_out;
	assign out_valid = out_valid_q;

	always_comb begin
		alpha_x = ADJ_W'(data_s2.alpha);
		beta_x  = ADJ_W'(data_s2.beta);
		case (data_s2.bound)
			BOUND_EXACT: cut = 1'b1;
			BOUND_LOWER: cut = data_s2.adj >= beta_x;
			BOUND_UPPER: cut = data_s2.adj <= alpha_x;
			default:     cut = 1'b0;
		endcase
		// clamp to the score field; the cutoff test keeps the full value
		if (data_s2.adj > SCORE_MAX) begin
			sat = SCORE_MAX[SCORE_W-1:0];
		end else if (data_s2.adj < SCORE_MIN) begin
			sat = SCORE_MIN[SCORE_W-1:0];
		end else begin
			sat = data_s2.adj[SCORE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_valid && s1_ready) begin
				valid_s2 <= 1'b1;
			end else if (load_out) begin
				valid_s2 <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid && s1_ready) begin
			data_s2 <= s1_data;
		end
		if (load_out) begin
			replaced    <= data_s2.replaced;
			key_hit     <= data_s2.key_hit;
			depth_hit   <= data_s2.depth_hit;
			cutoff      <= data_s2.depth_hit && cut;
			found_score <= data_s2.depth_hit ? sat : '0;
			found_move  <= data_s2.found_move;
		end
	end

endmodule

// ===== src/search_transposition_table.sv =====
// Top level of the search transposition table: entry memory, read-modify-write and config.
//
// Direct-mapped hash table for game search. Each input beat is a probe or a store; each
// gives exactly one result beat. An item holds the entry memory while the entry at the
// low key bits is read, checked and written back; no new item is taken until it leaves
// the read-modify-write stage, which out_stall can hold up. After reset the block clears
// the memory one entry a cycle and holds in_stall until every entry is cleared;
// configuration writes are taken at any time (cfg_ready is always high) but should be
// made only while no item is in flight.
module search_transposition_table
	import stt_pkg::*;
#(
	parameter int TABLE_ENTRIES = 65536,
	parameter int MOVE_BITS     = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         opcode,
	input  logic [63:0]                  key,
	input  logic [7:0]                   depth,
	input  logic [7:0]                   ply,
	input  logic signed [SCORE_W-1:0]    score,
	input  logic [1:0]                   bound_flag,
	input  logic [MOVE_W-1:0]            move,
	input  logic signed [SCORE_W-1:0]    alpha,
	input  logic signed [SCORE_W-1:0]    beta,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         replaced,
	output logic                         key_hit,
	output logic                         depth_hit,
	output logic                         cutoff,
	output logic signed [SCORE_W-1:0]    found_score,
	output logic [MOVE_W-1:0]            found_move,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int MV_W  = (MOVE_BITS < MOVE_W) ? MOVE_BITS : MOVE_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	typedef struct packed {
		logic [63:0]        check;
		logic signed [31:0] score;
		logic [7:0]         depth;
		logic [1:0]         bound;
		logic [MV_W-1:0]    mv;
		logic [7:0]         age;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// configuration
	logic [7:0]         age_q;
	logic signed [31:0] thr_hi_q;
	logic signed [31:0] thr_lo_q;

	// clearing pass
	logic             clr_busy_q;
	logic [IDX_W-1:0] clr_cnt_q;

	// item in the read-modify-write stage
	logic                      valid_s1;
	logic                      op_s1;
	logic [63:0]               key_s1;
	logic [7:0]                depth_s1;
	logic [7:0]                ply_s1;
	logic [1:0]                bound_s1;
	logic [MV_W-1:0]           move_s1;
	logic signed [SCORE_W-1:0] alpha_s1;
	logic signed [SCORE_W-1:0] beta_s1;
	logic signed [31:0]        st_s1;
	logic [63:0]               ck_s1;

	logic                accept;
	logic                s1_ready;
	logic signed [31:0]  sc_in;
	logic signed [31:0]  ply_in;
	logic signed [31:0]  st_in;
	logic                ram_we;
	logic [IDX_W-1:0]    ram_waddr;
	entry_t              wr_entry;
	logic [ENTRY_W-1:0]  ram_rdata;
	entry_t              rd;
	logic                same;
	logic                stale;
	logic                store_we;
	logic                dhit;
	logic signed [ADJ_W-1:0] rd_sc;
	logic signed [ADJ_W-1:0] rd_ply;
	stt_s2_t             s2_in;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = clr_busy_q || valid_s1;
	assign cfg_ready = 1'b1;

	// mate adjustment on the way in; the check key is formed from it as the item is registered
	always_comb begin
		sc_in  = 32'(score);
		ply_in = 32'($signed({1'b0, ply})) + PLY_EXTRA;
		if (sc_in > thr_hi_q) begin
			st_in = sc_in + ply_in;
		end else if (sc_in < thr_lo_q) begin
			st_in = sc_in - ply_in;
		end else begin
			st_in = sc_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_q      <= '0;
			thr_hi_q   <= THR_HI_RESET;
			thr_lo_q   <= THR_LO_RESET;
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
			valid_s1   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_AGE: age_q <= cfg_data[7:0];
					CFG_MATE: begin
						thr_hi_q <= $signed({2'b00, cfg_data}) - MATE_WINDOW;
						thr_lo_q <= MATE_WINDOW - $signed({2'b00, cfg_data});
					end
					default: ;
				endcase
			end
			if (clr_busy_q) begin
				if (clr_cnt_q == LAST_IDX) begin
					clr_busy_q <= 1'b0;
				end else begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
				end
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (valid_s1 && s1_ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= opcode;
			key_s1   <= key;
			depth_s1 <= depth;
			ply_s1   <= ply;
			bound_s1 <= bound_flag;
			move_s1  <= move[MV_W-1:0];
			alpha_s1 <= alpha;
			beta_s1  <= beta;
			st_s1    <= st_in;
			ck_s1    <= key ^ 64'(st_in);
		end
	end

	// check the entry read back, decide the write and form the probe fields
	always_comb begin
		rd     = entry_t'(ram_rdata);
		same   = (rd.check ^ 64'(rd.score)) == key_s1;
		stale  = rd.age != age_q;
		store_we = (op_s1 == OP_STORE) && (!same || stale || depth_s1 >= rd.depth);
		dhit   = (op_s1 != OP_STORE) && same && !stale && rd.depth >= depth_s1;
		rd_sc  = ADJ_W'(rd.score);
		rd_ply = ADJ_W'($signed({1'b0, ply_s1}));

		s2_in.replaced   = store_we;
		s2_in.key_hit    = (op_s1 != OP_STORE) && same;
		s2_in.depth_hit  = dhit;
		s2_in.bound      = rd.bound;
		s2_in.alpha      = alpha_s1;
		s2_in.beta       = beta_s1;
		s2_in.found_move = s2_in.key_hit ? MOVE_W'(rd.mv) : '0;
		if (rd.score > thr_hi_q) begin
			s2_in.adj = rd_sc - rd_ply;
		end else if (rd.score < thr_lo_q) begin
			s2_in.adj = rd_sc + rd_ply;
		end else begin
			s2_in.adj = rd_sc;
		end

		if (clr_busy_q) begin
			wr_entry = '0;
		end else begin
			wr_entry.check = ck_s1;
			wr_entry.score = st_s1;
			wr_entry.depth = depth_s1;
			wr_entry.bound = bound_s1;
			wr_entry.mv    = move_s1;
			wr_entry.age   = age_q;
		end
		ram_waddr = clr_busy_q ? clr_cnt_q : key_s1[IDX_W-1:0];
		// write back once, at the edge the item leaves this stage
		ram_we    = clr_busy_q || (valid_s1 && s1_ready && store_we);
	end

	stt_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wr_entry),
		.re    (accept),
		.raddr (key[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	stt_score_out u_score (
		.clk         (clk),
		.arst_n      (arst_n),
		.s1_valid    (valid_s1),
		.s1_ready    (s1_ready),
		.s1_data     (s2_in),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.replaced    (replaced),
		.key_hit     (key_hit),
		.depth_hit   (depth_hit),
		.cutoff      (cutoff),
		.found_score (found_score),
		.found_move  (found_move)
	);

endmodule

// ===== src/stt_checker.sv =====
// Port-level assertions for the search transposition table, bound to the top level.
module stt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        replaced,
	input logic        key_hit,
	input logic        depth_hit,
	input logic        cutoff,
	input logic [30:0] found_score,
	input logic [31:0] found_move
);

	// a held result beat keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(found_score) && $stable(found_move)
			&& $stable(replaced) && $stable(key_hit) && $stable(cutoff))
		else $error("stalled result changed");

	// the entry memory is busy for the cycle after an input beat
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken during read-modify-write");

	// a replacing store result carries no probe flags
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && replaced |-> !key_hit && !depth_hit && !cutoff)
		else $error("store result shows probe flags");

	// cutoff needs a depth hit, which needs a key hit
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (cutoff || depth_hit) |-> depth_hit && key_hit)
		else $error("hit flags out of order");

	// fields without their hit read as zero
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (key_hit || found_move == 32'd0) && (depth_hit || found_score == 31'd0))
		else $error("found field set without hit");

endmodule

bind search_transposition_table stt_checker u_stt_checker (.*);
